// ===== hw/rtl/gns_pkg.sv =====
// Shared constants, codes and transaction types of the grid neighbor search.
package gns_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int PW            = $clog2(MAX_PARTICLES);
    localparam int CNTW          = PW + 1;
    localparam int GRID_SIZE     = 32;
    localparam int GW            = $clog2(GRID_SIZE);
    localparam int CELLW         = 2 * GW;
    localparam int NCELLS        = GRID_SIZE * GRID_SIZE;
    localparam int CELL_CAPACITY = 16;
    localparam int CCW           = $clog2(CELL_CAPACITY);
    localparam int FW            = CCW + 1;
    localparam int MEMW          = CELLW + CCW;
    localparam int MAX_NEIGHBORS = 64;
    localparam int NBW           = $clog2(MAX_NEIGHBORS + 1);
    localparam int DRAIN_CYC     = 6;
    localparam int RADW          = 31;
    localparam int POSW          = 32;

    localparam logic [RADW-1:0] RADIUS_RESET = RADW'(65536);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_NEIGHBOR  = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_CELL_FULL = 3'd2;
    localparam logic [2:0] ST_STORE_FULL = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;

    typedef struct packed {
        logic [1:0]            op;
        logic signed [POSW-1:0] pos_x;
        logic signed [POSW-1:0] pos_y;
        logic [PW-1:0]         particle_index;
    } t_in;

    typedef struct packed {
        logic [PW-1:0] neighbor_index;
        logic [2:0]    status;
        logic          last;
    } t_out;

endpackage

// ===== hw/rtl/gns_div.sv =====
// Bit-serial divider that yields floor(value / radius) wrapped to a grid coordinate.
module gns_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gns_pkg::POSW-1:0]     i_val,
    input  logic [gns_pkg::RADW-1:0]     i_den,
    output logic                         o_done,
    output logic [gns_pkg::GW-1:0]       o_coord
);
    import gns_pkg::*;

    localparam int STW = $clog2(POSW);

    logic [POSW-1:0] r_num;
    logic [RADW-1:0] r_rem;
    logic [RADW-1:0] r_den;
    logic [GW-1:0]   r_q;
    logic            r_neg;
    logic            r_run;
    logic            r_done;
    logic [STW-1:0]  r_step;
    logic [POSW-1:0] sh;
    logic [POSW:0]   diff;
    logic            ge;
    logic [POSW-1:0] mag;

    assign mag  = i_val[POSW-1] ? (~i_val + POSW'(1)) : i_val;
    assign sh   = {r_rem, r_num[POSW-1]};
    assign diff = {1'b0, sh} - {2'b00, r_den};
    assign ge   = !diff[POSW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STW'(1);
                if (r_step == STW'(POSW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= mag;
            r_neg <= i_val[POSW-1];
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_run) begin
            r_num <= {r_num[POSW-2:0], 1'b0};
            r_rem <= ge ? diff[RADW-1:0] : sh[RADW-1:0];
            r_q   <= {r_q[GW-2:0], ge};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_coord = r_q;
        end else if (r_rem != '0) begin
            o_coord = ~r_q;
        end else begin
            o_coord = ~r_q + GW'(1);
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/gns_dist.sv =====
// Pipelined exact squared-distance test of one candidate against the queried particle.
module gns_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [gns_pkg::PW-1:0]        i_k,
    input  logic [gns_pkg::POSW-1:0]      i_px,
    input  logic [gns_pkg::POSW-1:0]      i_py,
    input  logic [gns_pkg::POSW-1:0]      i_ox,
    input  logic [gns_pkg::POSW-1:0]      i_oy,
    input  logic [2*gns_pkg::RADW-1:0]    i_r2,
    output logic                          o_vld,
    output logic [gns_pkg::PW-1:0]        o_k,
    output logic                          o_hit
);
    import gns_pkg::*;

    logic [POSW:0]     dx;
    logic [POSW:0]     dy;
    logic [POSW:0]     ndx;
    logic [POSW:0]     ndy;
    logic              r_vc;
    logic              r_vd;
    logic              r_ve;
    logic [PW-1:0]     r_kc;
    logic [PW-1:0]     r_kd;
    logic [PW-1:0]     r_ke;
    logic [POSW-1:0]   r_dxa;
    logic [POSW-1:0]   r_dya;
    logic [2*POSW-1:0] r_sx;
    logic [2*POSW-1:0] r_sy;
    logic              r_hit;
    logic [2*POSW:0]   sum;

    assign dx  = {i_px[POSW-1], i_px} - {i_ox[POSW-1], i_ox};
    assign dy  = {i_py[POSW-1], i_py} - {i_oy[POSW-1], i_oy};
    assign ndx = ~dx + (POSW+1)'(1);
    assign ndy = ~dy + (POSW+1)'(1);
    assign sum = {1'b0, r_sx} + {1'b0, r_sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_vc <= i_vld;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kc  <= i_k;
        r_dxa <= dx[POSW] ? ndx[POSW-1:0] : dx[POSW-1:0];
        r_dya <= dy[POSW] ? ndy[POSW-1:0] : dy[POSW-1:0];
        r_kd  <= r_kc;
        r_sx  <= r_dxa * r_dxa;
        r_sy  <= r_dya * r_dya;
        r_ke  <= r_kd;
        r_hit <= sum <= {3'b000, i_r2};
    end

    assign o_vld = r_ve;
    assign o_k   = r_ke;
    assign o_hit = r_hit;

endmodule

// ===== hw/rtl/grid_neighbor_search.sv =====
// Top level of the grid neighbor search: control sequencer, memories and result register.
//
// A load is paced by the 32-step bit-serial cell divider.
// A query scans the nine buckets around the queried particle's cell; the cell scan
// streams one member read per cycle within a bucket into the distance pipeline.
// A bad index is answered from idle.
// A clear, and the release of reset, sweeps the 1024 bucket fill counters while
// busy is high. Results appear on the strobe for one cycle each and must be
// taken then; the last result of a transaction carries last.
module grid_neighbor_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  gns_pkg::t_in                i_in,
    output logic                        o_strobe,
    output gns_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [gns_pkg::RADW-1:0]    i_cfg_wdata
);
    import gns_pkg::*;

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_LDIV   = 13'b0000000000100,
        S_LFILL  = 13'b0000000001000,
        S_LWR    = 13'b0000000010000,
        S_QRD    = 13'b0000000100000,
        S_QOWN   = 13'b0000001000000,
        S_QDIV   = 13'b0000010000000,
        S_QCELL  = 13'b0000100000000,
        S_QSCAN  = 13'b0001000000000,
        S_QDRAIN = 13'b0010000000000,
        S_QSELF  = 13'b0100000000000,
        S_QFIN   = 13'b1000000000000
    } t_state;

    logic [2*POSW-1:0] pos_mem [MAX_PARTICLES];
    logic [FW-1:0]     fill_mem [NCELLS];
    logic [PW-1:0]     member_mem [NCELLS*CELL_CAPACITY];

    t_state            r_state, n_state;
    logic [RADW-1:0]   r_rad;
    logic [RADW-1:0]   rad_eff;
    logic [CNTW-1:0]   r_count, n_count;
    logic [CELLW-1:0]  r_clr, n_clr;
    logic [POSW-1:0]   r_lx, n_lx;
    logic [POSW-1:0]   r_ly, n_ly;
    logic [PW-1:0]     r_pi, n_pi;
    logic [GW-1:0]     r_cx, n_cx;
    logic [GW-1:0]     r_cy, n_cy;
    logic [1:0]        r_ox, n_ox;
    logic [1:0]        r_oy, n_oy;
    logic [FW-1:0]     r_m, n_m;
    logic [NBW-1:0]    r_n, n_n;
    logic              r_trunc, n_trunc;
    logic              r_self, n_self;
    logic              r_pend_v, n_pend_v;
    logic [PW-1:0]     r_pend_k, n_pend_k;
    logic [2:0]        r_drain, n_drain;
    logic [POSW-1:0]   r_own_x, n_own_x;
    logic [POSW-1:0]   r_own_y, n_own_y;
    logic [2*RADW-1:0] r_r2, n_r2;
    logic              r_out_vld, n_out_vld;
    t_out              r_out, n_out;

    logic [GW-1:0]     gx, gy;
    logic [CELLW-1:0]  fill_addr;
    logic [FW-1:0]     r_fill_q;
    logic              fill_we;
    logic [CELLW-1:0]  fill_waddr;
    logic [FW-1:0]     fill_wdata;
    logic [MEMW-1:0]   member_addr;
    logic [PW-1:0]     r_mem_q;
    logic              member_we;
    logic [PW-1:0]     pos_raddr;
    logic [2*POSW-1:0] r_pos_q;
    logic              pos_we;
    logic              issue;
    logic              r_pa_v;
    logic              r_pb_v;
    logic [PW-1:0]     r_pb_k;
    logic              div_start;
    logic [POSW-1:0]   div_x, div_y;
    logic              done_x, done_y;
    logic [GW-1:0]     coord_x, coord_y;
    logic              dist_vld;
    logic [PW-1:0]     dist_k;
    logic              dist_hit;

    assign rad_eff = (r_rad == '0) ? RADW'(1) : r_rad;
    assign gx = r_cx + GW'(r_ox) - GW'(1);
    assign gy = r_cy + GW'(r_oy) - GW'(1);
    assign fill_addr = (r_state == S_LFILL || r_state == S_LWR) ? {r_cx, r_cy} : {gx, gy};
    assign member_addr = {gx, gy, r_m[CCW-1:0]};
    assign pos_raddr = (r_state == S_QRD) ? r_pi : r_mem_q;
    assign issue = (r_state == S_QSCAN) && (r_m < r_fill_q);
    assign div_x = (r_state == S_IDLE) ? i_in.pos_x : r_pos_q[2*POSW-1:POSW];
    assign div_y = (r_state == S_IDLE) ? i_in.pos_y : r_pos_q[POSW-1:0];

    gns_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_val   (div_x),
        .i_den   (rad_eff),
        .o_done  (done_x),
        .o_coord (coord_x)
    );

    gns_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_val   (div_y),
        .i_den   (rad_eff),
        .o_done  (done_y),
        .o_coord (coord_y)
    );

    gns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_pb_v),
        .i_k     (r_pb_k),
        .i_px    (r_pos_q[2*POSW-1:POSW]),
        .i_py    (r_pos_q[POSW-1:0]),
        .i_ox    (r_own_x),
        .i_oy    (r_own_y),
        .i_r2    (r_r2),
        .o_vld   (dist_vld),
        .o_k     (dist_k),
        .o_hit   (dist_hit)
    );

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_q <= fill_mem[fill_addr];
    end

    always_ff @(posedge i_clk) begin
        if (member_we) begin
            member_mem[{r_cx, r_cy, r_fill_q[CCW-1:0]}] <= r_count[PW-1:0];
        end
        r_mem_q <= member_mem[member_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[r_count[PW-1:0]] <= {r_lx, r_ly};
        end
        r_pos_q <= pos_mem[pos_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_clr     = r_clr;
        n_lx      = r_lx;
        n_ly      = r_ly;
        n_pi      = r_pi;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_m       = r_m;
        n_n       = r_n;
        n_trunc   = r_trunc;
        n_self    = r_self;
        n_pend_v  = r_pend_v;
        n_pend_k  = r_pend_k;
        n_drain   = r_drain;
        n_own_x   = r_own_x;
        n_own_y   = r_own_y;
        n_r2      = r_r2;
        n_out_vld = 1'b0;
        n_out     = r_out;
        div_start = 1'b0;
        fill_we   = 1'b0;
        fill_waddr = r_clr;
        fill_wdata = '0;
        member_we = 1'b0;
        pos_we    = 1'b0;

        if (dist_vld && dist_hit && !r_trunc) begin
            if (r_n == NBW'(MAX_NEIGHBORS)) begin
                n_trunc = 1'b1;
            end else begin
                if (dist_k == r_pi) begin
                    n_self = 1'b1;
                end
                if (r_pend_v) begin
                    n_out_vld = 1'b1;
                    n_out = '{neighbor_index: r_pend_k, status: ST_NEIGHBOR, last: 1'b0};
                end
                n_pend_k = dist_k;
                n_pend_v = 1'b1;
                n_n = r_n + NBW'(1);
            end
        end

        unique case (r_state)
            S_CLR: begin
                fill_we = 1'b1;
                n_clr = r_clr + CELLW'(1);
                if (r_clr == CELLW'(NCELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_in.op)
                        OP_LOAD: begin
                            if (r_count >= CNTW'(MAX_PARTICLES)) begin
                                n_out_vld = 1'b1;
                                n_out = '{neighbor_index: '0, status: ST_STORE_FULL,
                                          last: 1'b1};
                            end else begin
                                n_lx = i_in.pos_x;
                                n_ly = i_in.pos_y;
                                div_start = 1'b1;
                                n_state = S_LDIV;
                            end
                        end
                        OP_QUERY: begin
                            n_pi = i_in.particle_index;
                            if ({1'b0, i_in.particle_index} >= r_count) begin
                                n_out_vld = 1'b1;
                                n_out = '{neighbor_index: i_in.particle_index,
                                          status: ST_BAD_INDEX, last: 1'b1};
                            end else begin
                                n_r2 = rad_eff * rad_eff;
                                n_n = '0;
                                n_trunc = 1'b0;
                                n_self = 1'b0;
                                n_pend_v = 1'b0;
                                n_state = S_QRD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_clr = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LDIV: begin
                if (done_x && done_y) begin
                    n_cx = coord_x;
                    n_cy = coord_y;
                    n_state = S_LFILL;
                end
            end
            S_LFILL: begin
                n_state = S_LWR;
            end
            S_LWR: begin
                n_out_vld = 1'b1;
                if (r_fill_q >= FW'(CELL_CAPACITY)) begin
                    n_out = '{neighbor_index: '0, status: ST_CELL_FULL, last: 1'b1};
                end else begin
                    fill_we = 1'b1;
                    fill_waddr = {r_cx, r_cy};
                    fill_wdata = r_fill_q + FW'(1);
                    member_we = 1'b1;
                    pos_we = 1'b1;
                    n_count = r_count + CNTW'(1);
                    n_out = '{neighbor_index: r_count[PW-1:0], status: ST_ACCEPTED,
                              last: 1'b1};
                end
                n_state = S_IDLE;
            end
            S_QRD: begin
                n_state = S_QOWN;
            end
            S_QOWN: begin
                n_own_x = r_pos_q[2*POSW-1:POSW];
                n_own_y = r_pos_q[POSW-1:0];
                div_start = 1'b1;
                n_state = S_QDIV;
            end
            S_QDIV: begin
                if (done_x && done_y) begin
                    n_cx = coord_x;
                    n_cy = coord_y;
                    n_ox = '0;
                    n_oy = '0;
                    n_state = S_QCELL;
                end
            end
            S_QCELL: begin
                n_m = '0;
                n_state = S_QSCAN;
            end
            S_QSCAN: begin
                if (issue) begin
                    n_m = r_m + FW'(1);
                end else if (r_oy != 2'd2) begin
                    n_oy = r_oy + 2'd1;
                    n_state = S_QCELL;
                end else if (r_ox != 2'd2) begin
                    n_oy = '0;
                    n_ox = r_ox + 2'd1;
                    n_state = S_QCELL;
                end else begin
                    n_drain = '0;
                    n_state = S_QDRAIN;
                end
            end
            S_QDRAIN: begin
                n_drain = r_drain + 3'd1;
                if (r_drain == 3'(DRAIN_CYC - 1)) begin
                    n_state = S_QSELF;
                end
            end
            S_QSELF: begin
                if (!r_trunc && !r_self) begin
                    if (r_n == NBW'(MAX_NEIGHBORS)) begin
                        n_trunc = 1'b1;
                    end else begin
                        if (r_pend_v) begin
                            n_out_vld = 1'b1;
                            n_out = '{neighbor_index: r_pend_k, status: ST_NEIGHBOR,
                                      last: 1'b0};
                        end
                        n_pend_k = r_pi;
                        n_pend_v = 1'b1;
                        n_n = r_n + NBW'(1);
                    end
                end
                n_state = S_QFIN;
            end
            S_QFIN: begin
                n_out_vld = 1'b1;
                n_out = '{neighbor_index: r_pend_k,
                          status: r_trunc ? ST_TRUNCATED : ST_NEIGHBOR, last: 1'b1};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_count   <= '0;
            r_rad     <= RADIUS_RESET;
            r_out_vld <= 1'b0;
            r_pa_v    <= 1'b0;
            r_pb_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_pa_v    <= issue;
            r_pb_v    <= r_pa_v;
            if (i_cfg_we) begin
                r_rad <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lx     <= n_lx;
        r_ly     <= n_ly;
        r_pi     <= n_pi;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_m      <= n_m;
        r_n      <= n_n;
        r_trunc  <= n_trunc;
        r_self   <= n_self;
        r_pend_v <= n_pend_v;
        r_pend_k <= n_pend_k;
        r_drain  <= n_drain;
        r_own_x  <= n_own_x;
        r_own_y  <= n_own_y;
        r_r2     <= n_r2;
        r_out    <= n_out;
        r_pb_k   <= r_mem_q;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_out    = r_out;

`ifndef SYNTHESIS
    a_accept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.status == ST_ACCEPTED) |-> (r_count == $past(r_count) + CNTW'(1)))
        else $error("Accepted load did not advance the particle count.");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (!r_pa_v && !r_pb_v && !dist_vld))
        else $error("Distance pipeline holds a candidate while idle.");

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && $past(r_state) == S_CLR) |-> !o_strobe)
        else $error("Result issued during the clearing sweep.");

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_QFIN) |-> (o_strobe && o_out.last))
        else $error("Query did not end with a last result.");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the grid neighbor search block.
`timescale 1ns / 100ps

module testbench;
    import gns_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 6000;

    class neighbor_scoreboard;
        logic [RADW-1:0] radius;
        logic [POSW-1:0] store_x [MAX_PARTICLES];
        logic [POSW-1:0] store_y [MAX_PARTICLES];
        int unsigned count;
        int unsigned fill [NCELLS];
        int unsigned members [NCELLS * CELL_CAPACITY];
        t_out pending [$];
        int errors;
        int results_seen;

        function new();
            radius = RADIUS_RESET;
            count = 0;
            errors = 0;
            results_seen = 0;
            foreach (fill[i]) fill[i] = 0;
        endfunction

        function void queue_result(t_out e);
            pending.insert(pending.size(), e);
        endfunction

        function longint radius_now();
            return (radius == 0) ? 1 : longint'(radius);
        endfunction

        function int unsigned cell_of(logic [POSW-1:0] p, longint r);
            longint v;
            longint q;
            longint m;
            v = longint'($signed(p));
            q = v / r;
            if ((v % r) != 0 && v < 0) q = q - 1;
            m = q % GRID_SIZE;
            if (m < 0) m = m + GRID_SIZE;
            return int'(m);
        endfunction

        function bit is_near(int unsigned a, int unsigned b, longint r);
            longint unsigned r2;
            longint unsigned dx;
            longint unsigned dy;
            longint ax;
            longint bx;
            longint ay;
            longint by;
            r2 = longint'(r) * longint'(r);
            ax = longint'($signed(store_x[a]));
            bx = longint'($signed(store_x[b]));
            ay = longint'($signed(store_y[a]));
            by = longint'($signed(store_y[b]));
            dx = (ax >= bx) ? ax - bx : bx - ax;
            dy = (ay >= by) ? ay - by : by - ay;
            if (dx * dx > r2) return 0;
            return (dy * dy) <= (r2 - dx * dx);
        endfunction

        function void note_transaction(t_in x);
            longint r;
            int unsigned bucket;
            int unsigned pi;
            int unsigned cx;
            int unsigned cy;
            int unsigned k;
            bit self_seen;
            bit truncated;
            t_out found [$];
            r = radius_now();
            case (x.op)
                OP_LOAD: begin
                    if (count >= MAX_PARTICLES) begin
                        queue_result('{0, ST_STORE_FULL, 1'b1});
                    end else begin
                        bucket = cell_of(x.pos_x, r) * GRID_SIZE + cell_of(x.pos_y, r);
                        if (fill[bucket] >= CELL_CAPACITY) begin
                            queue_result('{0, ST_CELL_FULL, 1'b1});
                        end else begin
                            store_x[count] = x.pos_x;
                            store_y[count] = x.pos_y;
                            members[bucket * CELL_CAPACITY + fill[bucket]] = count;
                            fill[bucket]++;
                            queue_result('{PW'(count), ST_ACCEPTED, 1'b1});
                            count++;
                        end
                    end
                end
                OP_QUERY: begin
                    pi = x.particle_index;
                    if (pi >= count) begin
                        queue_result('{PW'(pi), ST_BAD_INDEX, 1'b1});
                    end else begin
                        cx = cell_of(store_x[pi], r);
                        cy = cell_of(store_y[pi], r);
                        self_seen = 0;
                        truncated = 0;
                        for (int dx = -1; dx <= 1 && !truncated; dx++) begin
                            for (int dy = -1; dy <= 1 && !truncated; dy++) begin
                                bucket = ((cx + dx + GRID_SIZE) % GRID_SIZE) * GRID_SIZE
                                       + ((cy + dy + GRID_SIZE) % GRID_SIZE);
                                for (int m = 0; m < fill[bucket]; m++) begin
                                    k = members[bucket * CELL_CAPACITY + m];
                                    if (!is_near(pi, k, r)) continue;
                                    if (found.size() >= MAX_NEIGHBORS) begin
                                        truncated = 1;
                                        break;
                                    end
                                    if (k == pi) self_seen = 1;
                                    found.insert(found.size(), '{PW'(k), ST_NEIGHBOR, 1'b0});
                                end
                            end
                        end
                        if (!self_seen && !truncated) begin
                            if (found.size() >= MAX_NEIGHBORS) truncated = 1;
                            else found.insert(found.size(), '{PW'(pi), ST_NEIGHBOR, 1'b0});
                        end
                        if (truncated) found[found.size() - 1].status = ST_TRUNCATED;
                        found[found.size() - 1].last = 1'b1;
                        foreach (found[i]) queue_result(found[i]);
                    end
                end
                OP_CLEAR: begin
                    count = 0;
                    foreach (fill[i]) fill[i] = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out y);
            t_out e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result index %0d status %0d", y.neighbor_index, y.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (y.neighbor_index !== e.neighbor_index) begin
                $error("neighbor_index expected %0d actual %0d", e.neighbor_index,
                       y.neighbor_index);
                errors++;
            end
            if (y.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, y.status);
                errors++;
            end
            if (y.last !== e.last) begin
                $error("last expected %0d actual %0d", e.last, y.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in in_item;
    logic o_strobe;
    t_out o_out;
    logic i_cfg_we;
    logic [RADW-1:0] i_cfg_wdata;

    neighbor_scoreboard sb;
    int idle_cycles = 0;
    int sent;
    bit quiet_phase;

    grid_neighbor_search i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (in_item),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_out);
        if (i_rst_n && ((start && !busy) || o_strobe)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("grid_neighbor_search regression: fail");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [POSW-1:0] x, logic [POSW-1:0] y,
                        logic [PW-1:0] idx);
        int gap;
        in_item <= '{op, x, y, idx};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_transaction('{op, x, y, idx});
        sent++;
        if (!quiet_phase && $urandom_range(0, 1) == 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_radius(logic [RADW-1:0] r, bit and_clear);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.radius = r;
        if (and_clear) send(OP_CLEAR, 0, 0, 0);
    endtask

    function automatic logic [POSW-1:0] pick_pos(longint r);
        longint v;
        if ($urandom_range(0, 9) == 0) return $urandom;
        v = (longint'($urandom_range(0, 4000)) * r) / 1000 - 2 * r;
        return v[POSW-1:0];
    endfunction

    task automatic random_mix(int n);
        int c;
        longint r;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 99);
            r = sb.radius_now();
            if (c < 55) send(OP_LOAD, pick_pos(r), pick_pos(r), PW'($urandom));
            else if (c < 88 && sb.count > 0)
                send(OP_QUERY, $urandom, $urandom, PW'($urandom_range(0, sb.count - 1)));
            else if (c < 94) send(OP_QUERY, $urandom, $urandom,
                                  PW'($urandom_range(sb.count, MAX_PARTICLES - 1)));
            else if (c < 97) send(OP_CLEAR, $urandom, $urandom, PW'($urandom));
            else send(OP_UNUSED, $urandom, $urandom, PW'($urandom));
        end
    endtask

    initial begin
        logic [RADW-1:0] radii [6];
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        sent = 0;
        quiet_phase = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, wrap neighbors, far wrapped cells, bad index, op 3.
        send(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 0);
        send(OP_LOAD, 32'h0000_FFFF, 32'h0000_FFFF, 0);
        send(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(OP_LOAD, 32'h001F_000A, 32'h0000_0000, 0);
        send(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 0, 2);
        send(OP_QUERY, 0, 0, 4);
        send(OP_QUERY, 0, 0, 10'h3FF);
        send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        for (int i = 0; i < 17; i++) send(OP_LOAD, 32'(i), 32'(2 * i), 0);
        send(OP_QUERY, 0, 0, 7);

        // Dense cluster around the origin to overflow the neighbor list.
        set_radius(RADW'(65536), 1);
        for (int q = 0; q < 4; q++)
            for (int i = 0; i < 16; i++)
                send(OP_LOAD, (q[0] ? -32'(i + 1) : 32'(i + 1)),
                     (q[1] ? -32'(i + 1) : 32'(i + 1)), 0);
        for (int i = 0; i < 8; i++) send(OP_LOAD, 32'h0001_0000, 32'(i), 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 0, 70);

        // Radius change without a clear: the queried particle may be off the scan.
        set_radius(RADW'(3), 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 0, 65);

        radii = '{RADW'(1), RADW'(0), {RADW{1'b1}}, RADW'(65536), RADW'(40000),
                  RADW'($urandom)};
        foreach (radii[p]) begin
            set_radius(radii[p], 1);
            quiet_phase = (p == 2);
            random_mix(53);
        end
        quiet_phase = 0;

        // Scattered particles, then queries of random indexes.
        set_radius(RADW'(65536), 1);
        for (int i = 0; i < 20; i++) send(OP_LOAD, $urandom, $urandom, 0);
        for (int i = 0; i < 30; i++) send(OP_QUERY, 0, 0, PW'($urandom));
        send(OP_CLEAR, 0, 0, 0);

        wait_idle();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d transactions and %0d results over several radius settings,",
                 sent, sb.results_seen);
        $display("including full cells, truncation, bad indexes and stale buckets.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("grid_neighbor_search regression: pass");
        end else begin
            $display("grid_neighbor_search regression: fail");
        end
        $finish;
    end
endmodule
